>>> sv/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, constants and types for the atlas tile placer.
// ----------------------------------------------------------------------------
package atp_pkg;

   localparam int XW = 13;
   localparam int YW = 16;

   localparam logic [XW-1:0] PAGE_WIDTH_RESET = 13'd1024;
   localparam logic [YW-1:0] Y_MAX            = 16'hFFFF;

   typedef struct packed {
      logic [XW-1:0] column_left;
      logic [XW-1:0] cursor_x;
      logic [XW-1:0] column_right_max;
      logic [YW-1:0] shelf_top;
      logic [YW-1:0] cursor_y;
      logic [YW-1:0] shelf_bottom;
   } place_state_type;

   typedef struct packed {
      logic [XW-1:0] tile_width;
      logic [XW-1:0] tile_height;
      logic          new_page;
   } tile_type;

   typedef struct packed {
      logic [XW-1:0] left_x;
      logic [YW-1:0] top_y;
      logic [XW-1:0] right_x;
      logic [YW-1:0] bottom_y;
      logic [YW-1:0] page_height;
      logic          too_wide;
      logic          height_overflow;
   } place_result_type;

endpackage

>>> sv/atp_place.sv
// ----------------------------------------------------------------------------
// atp_place
// Single-pass placement step: from the current cursor state and one tile,
// forms the placed rectangle and the next cursor state.
// ----------------------------------------------------------------------------
module atp_place (
   input  atp_pkg::place_state_type  state_i,
   input  atp_pkg::tile_type         tile_i,
   input  logic [atp_pkg::XW-1:0]    page_width,
   output atp_pkg::place_state_type  state_o,
   output atp_pkg::place_result_type result_o
);

   function automatic atp_pkg::place_state_type open_shelf(
      input atp_pkg::place_state_type s_i
   );
      atp_pkg::place_state_type s;
      s                  = s_i;
      s.shelf_top        = s_i.shelf_bottom;
      s.cursor_y         = s_i.shelf_bottom;
      s.column_left      = '0;
      s.cursor_x         = '0;
      s.column_right_max = '0;
      return s;
   endfunction

   function automatic logic x_overrun(
      input logic [atp_pkg::XW-1:0] x,
      input logic [atp_pkg::XW-1:0] w,
      input logic [atp_pkg::XW-1:0] pw
   );
      return ({1'b0, x} + {1'b0, w}) > {1'b0, pw};
   endfunction

   atp_pkg::place_state_type s;
   logic [atp_pkg::YW:0]     y_sum;
   logic [atp_pkg::YW:0]     grow_sum;
   logic [atp_pkg::YW-1:0]   grow;
   logic [atp_pkg::YW-1:0]   bottom;
   logic [atp_pkg::XW:0]     right_sum;
   logic [atp_pkg::XW-1:0]   right;
   logic                     ovf;

   always_comb begin
      s        = state_i;
      ovf      = 1'b0;
      grow     = '0;
      grow_sum = '0;

      if (tile_i.new_page) begin
         s = '0;
      end

      if (x_overrun(s.cursor_x, tile_i.tile_width, page_width)) begin
         s = open_shelf(s);
      end

      y_sum = {1'b0, s.cursor_y} + {4'b0, tile_i.tile_height};
      if (y_sum >= {1'b0, s.shelf_bottom}) begin
         if (s.cursor_y != s.shelf_top) begin
            s.cursor_y    = s.shelf_top;
            s.cursor_x    = s.column_right_max;
            s.column_left = s.column_right_max;
         end
         if (x_overrun(s.cursor_x, tile_i.tile_width, page_width)) begin
            s = open_shelf(s);
         end
         if (s.cursor_y == s.shelf_top) begin
            grow_sum = {1'b0, s.shelf_top} + {4'b0, tile_i.tile_height};
            if (grow_sum[atp_pkg::YW]) begin
               ovf  = 1'b1;
               grow = atp_pkg::Y_MAX;
            end else begin
               grow = grow_sum[atp_pkg::YW-1:0];
            end
            if (grow > s.shelf_bottom) begin
               s.shelf_bottom = grow;
            end
         end
      end

      right_sum = {1'b0, s.cursor_x} + {1'b0, tile_i.tile_width};
      right     = right_sum[atp_pkg::XW-1:0];
      y_sum     = {1'b0, s.cursor_y} + {4'b0, tile_i.tile_height};
      if (y_sum[atp_pkg::YW]) begin
         ovf    = 1'b1;
         bottom = atp_pkg::Y_MAX;
      end else begin
         bottom = y_sum[atp_pkg::YW-1:0];
      end

      result_o.left_x          = s.cursor_x;
      result_o.top_y           = s.cursor_y;
      result_o.right_x         = right;
      result_o.bottom_y        = bottom;
      result_o.page_height     = s.shelf_bottom;
      result_o.too_wide        = tile_i.tile_width > page_width;
      result_o.height_overflow = ovf;

      if (right > s.column_right_max) begin
         s.column_right_max = right;
      end
      s.cursor_x = s.column_left;
      s.cursor_y = bottom;
      state_o    = s;
   end

endmodule

>>> sv/atlas_tile_placer.sv
// ----------------------------------------------------------------------------
// atlas_tile_placer
// Shelf-and-column tile placer for one texture page.
//
//   channel | dir | handshake              | word
//   req_    | in  | req_valid / req_stall  | tile width, height, new_page
//   rsp_    | out | rsp_valid / rsp_stall  | rectangle, page height, flags
//   csr_    | in  | csr_valid / csr_ready  | page_width
//
// One word per cycle sustained while rsp_stall is low; each word passes the
// input register, then the result register. The placement step and the
// cursor update happen in the same cycle, which sets the rate. Reset clears
// the cursor state and loads page_width with 1024. A stalled result holds
// the pipeline; the input register still takes one word while it is empty.
// ----------------------------------------------------------------------------
module atlas_tile_placer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [atp_pkg::XW-1:0]    req_tile_width,
   input  logic [atp_pkg::XW-1:0]    req_tile_height,
   input  logic                      req_new_page,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [atp_pkg::XW-1:0]    rsp_left_x,
   output logic [atp_pkg::YW-1:0]    rsp_top_y,
   output logic [atp_pkg::XW-1:0]    rsp_right_x,
   output logic [atp_pkg::YW-1:0]    rsp_bottom_y,
   output logic [atp_pkg::YW-1:0]    rsp_page_height,
   output logic                      rsp_too_wide,
   output logic                      rsp_height_overflow,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [atp_pkg::XW-1:0]    csr_page_width
);

   logic                      in_valid_ff, in_valid_in;
   atp_pkg::tile_type         tile_ff, tile_in;
   logic                      out_valid_ff, out_valid_in;
   atp_pkg::place_result_type result_ff, result_in;
   atp_pkg::place_state_type  state_ff, state_in;
   logic [atp_pkg::XW-1:0]    page_width_ff, page_width_in;

   logic                      out_free;
   logic                      step;
   logic                      req_take;

   atp_pkg::place_state_type  state_next;
   atp_pkg::place_result_type result_next;

   atp_place u_place (
      .state_i    (state_ff),
      .tile_i     (tile_ff),
      .page_width (page_width_ff),
      .state_o    (state_next),
      .result_o   (result_next)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in   = in_valid_ff;
      tile_in       = tile_ff;
      out_valid_in  = out_valid_ff;
      result_in     = result_ff;
      state_in      = state_ff;
      page_width_in = page_width_ff;

      if (step) begin
         in_valid_in = 1'b0;
         state_in    = state_next;
         result_in   = result_next;
      end
      if (req_take) begin
         in_valid_in          = 1'b1;
         tile_in.tile_width   = req_tile_width;
         tile_in.tile_height  = req_tile_height;
         tile_in.new_page     = req_new_page;
      end
      if (out_free) begin
         out_valid_in = step;
      end
      if (csr_valid && csr_ready) begin
         page_width_in = csr_page_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         page_width_ff <= atp_pkg::PAGE_WIDTH_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
         page_width_ff <= page_width_in;
      end
      tile_ff   <= tile_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_left_x          = result_ff.left_x;
   assign rsp_top_y           = result_ff.top_y;
   assign rsp_right_x         = result_ff.right_x;
   assign rsp_bottom_y        = result_ff.bottom_y;
   assign rsp_page_height     = result_ff.page_height;
   assign rsp_too_wide        = result_ff.too_wide;
   assign rsp_height_overflow = result_ff.height_overflow;

endmodule
